// ----- src/base64_decoder_qp_tolerant_defines.svh -----
// Assertion macros shared by the base64 decoder RTL.
`ifndef BASE64_DECODER_QP_TOLERANT_DEFINES_SVH
`define BASE64_DECODER_QP_TOLERANT_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define B64D_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64d: same-cycle implication failed");

// Checks that a condition implies another in the following cycle.
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64d: next-cycle implication failed");

`endif

// ----- src/b64d_pkg.sv -----
// Types, codes and decode functions of the base64 decoder.
package b64d_pkg;

  // Queue between the front and back parts; depth must be a power of two.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Characters that the decoder looks for.
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_UD   = 8'h44;
  localparam logic [7:0] CH_LD   = 8'h64;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UZ   = 8'h5A;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7A;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [5:0] SX_F    = 6'd5;

  // Escape progress codes.
  localparam logic [3:0] ESC_NONE       = 4'd0;
  localparam logic [3:0] ESC_P0_EQ      = 4'd1;
  localparam logic [3:0] ESC_P0_EQ4     = 4'd2;
  localparam logic [3:0] ESC_P2_EQ      = 4'd3;
  localparam logic [3:0] ESC_P2_EQ3     = 4'd4;
  localparam logic [3:0] ESC_P2_EQ3D    = 4'd5;
  localparam logic [3:0] ESC_P2_EQ3DEQ  = 4'd6;
  localparam logic [3:0] ESC_P2_EQ3DEQ3 = 4'd7;
  localparam logic [3:0] ESC_P2_EQEQ    = 4'd8;
  localparam logic [3:0] ESC_P2_EQEQ3   = 4'd9;
  localparam logic [3:0] ESC_P3_EQ      = 4'd10;
  localparam logic [3:0] ESC_P3_EQ3     = 4'd11;

  // Replay codes returned by one character step.
  localparam logic [1:0] RET_DONE     = 2'd0;
  localparam logic [1:0] RET_REPLAY_C = 2'd1;
  localparam logic [1:0] RET_REPLAY_3 = 2'd2;

  localparam logic [1:0] MAX_RES = 2'd3;

  typedef struct packed {
    logic [1:0]  gpos;
    logic [17:0] store;
    logic [3:0]  esc;
    logic        disc;
  } dec_state_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
    logic [2:0]      bad;
  } res_set_t;

  typedef struct packed {
    dec_state_t st;
    res_set_t   rs;
  } step_t;

  typedef struct packed {
    step_t      sr;
    logic [1:0] ret;
  } take_t;

  // One queue entry: the results of one request and its end-of-text mark.
  typedef struct packed {
    res_set_t rs;
    logic     fin;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Maps a character to its sextet; bit 6 set means not in the alphabet.
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd26;
    end else if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0 + 8'd52;
    end else if (c == CH_PLUS) begin
      d = 8'd62;
    end else if (c == CH_DIV) begin
      d = 8'd63;
    end else begin
      d = 8'd64;
    end
    return d[6:0];
  endfunction

  function automatic logic is_d(logic [7:0] c);
    return (c == CH_UD) || (c == CH_LD);
  endfunction

  function automatic logic [17:0] push_sextet(logic [17:0] st, logic [5:0] v);
    return {st[11:0], v};
  endfunction

  // Appends one result unless three are already there.
  function automatic res_set_t emit_res(res_set_t r, logic [7:0] b, logic bad);
    res_set_t o;
    o = r;
    if (r.cnt != MAX_RES) begin
      o.data[r.cnt] = b;
      o.bad[r.cnt]  = bad;
      o.cnt         = r.cnt + 2'd1;
    end
    return o;
  endfunction

  function automatic step_t clear_group(step_t x);
    step_t o;
    o          = x;
    o.st.gpos  = 2'd0;
    o.st.store = 18'd0;
    o.st.esc   = ESC_NONE;
    return o;
  endfunction

  function automatic step_t fail_fn(step_t x);
    step_t o;
    o         = x;
    o.rs      = emit_res(o.rs, 8'd0, 1'b1);
    o         = clear_group(o);
    o.st.disc = 1'b1;
    return o;
  endfunction

  // Closes a group with the stored three sextets and s3, giving nb bytes.
  function automatic step_t close_fn(step_t x, logic [5:0] s3, logic [1:0] nb);
    step_t      o;
    logic [5:0] s0;
    logic [5:0] s1;
    logic [5:0] s2;
    o  = x;
    s0 = x.st.store[17:12];
    s1 = x.st.store[11:6];
    s2 = x.st.store[5:0];
    o.rs = emit_res(o.rs, {s0, s1[5:4]}, 1'b0);
    if (nb > 2'd1) begin
      o.rs = emit_res(o.rs, {s1[3:0], s2[5:2]}, 1'b0);
    end
    if (nb > 2'd2) begin
      o.rs = emit_res(o.rs, {s2[1:0], s3}, 1'b0);
    end
    o = clear_group(o);
    return o;
  endfunction

  function automatic step_t pads_fn(step_t x);
    step_t o;
    o          = x;
    o.st.store = push_sextet(x.st.store, 6'd0);
    return close_fn(o, 6'd0, 2'd1);
  endfunction

  // Handles one character against the current state.
  function automatic take_t take_fn(step_t x, logic [7:0] c);
    take_t      t;
    logic [6:0] sx;
    logic       do_fail;
    t.sr    = x;
    t.ret   = RET_DONE;
    sx      = sextet_of(c);
    do_fail = 1'b0;
    if (!x.st.disc) begin
      unique case (x.st.esc)
        ESC_NONE: begin
          if (c == CH_EQ && x.st.gpos != 2'd1) begin
            t.sr.st.esc = (x.st.gpos == 2'd0) ? ESC_P0_EQ :
                          (x.st.gpos == 2'd2) ? ESC_P2_EQ : ESC_P3_EQ;
          end else if (sx[6]) begin
            do_fail = 1'b1;
          end else if (x.st.gpos == 2'd3) begin
            t.sr = close_fn(x, sx[5:0], 2'd3);
          end else begin
            t.sr.st.store = push_sextet(x.st.store, sx[5:0]);
            t.sr.st.gpos  = x.st.gpos + 2'd1;
          end
        end
        ESC_P0_EQ: begin
          if (c == CH_4) t.sr.st.esc = ESC_P0_EQ4;
          else do_fail = 1'b1;
        end
        ESC_P0_EQ4: begin
          if (c == CH_6) begin
            t.sr.st.store = push_sextet(x.st.store, SX_F);
            t.sr.st.gpos  = 2'd1;
            t.sr.st.esc   = ESC_NONE;
          end else begin
            do_fail = 1'b1;
          end
        end
        ESC_P2_EQ: begin
          if (c == CH_3) t.sr.st.esc = ESC_P2_EQ3;
          else if (c == CH_EQ) t.sr.st.esc = ESC_P2_EQEQ;
          else do_fail = 1'b1;
        end
        ESC_P2_EQ3: begin
          if (is_d(c)) t.sr.st.esc = ESC_P2_EQ3D;
          else do_fail = 1'b1;
        end
        ESC_P2_EQ3D: begin
          if (c == CH_EQ) t.sr.st.esc = ESC_P2_EQ3DEQ;
          else do_fail = 1'b1;
        end
        ESC_P2_EQ3DEQ: begin
          if (c == CH_3) t.sr.st.esc = ESC_P2_EQ3DEQ3;
          else do_fail = 1'b1;
        end
        ESC_P2_EQ3DEQ3: begin
          if (is_d(c)) t.sr = pads_fn(x);
          else do_fail = 1'b1;
        end
        ESC_P2_EQEQ: begin
          if (c == CH_3) begin
            t.sr.st.esc = ESC_P2_EQEQ3;
          end else begin
            t.sr  = pads_fn(x);
            t.ret = RET_REPLAY_C;
          end
        end
        ESC_P2_EQEQ3: begin
          if (is_d(c)) begin
            do_fail = 1'b1;
          end else begin
            t.sr  = pads_fn(x);
            t.ret = RET_REPLAY_3;
          end
        end
        ESC_P3_EQ: begin
          if (c == CH_3) begin
            t.sr.st.esc = ESC_P3_EQ3;
          end else begin
            t.sr  = close_fn(x, 6'd0, 2'd2);
            t.ret = RET_REPLAY_C;
          end
        end
        ESC_P3_EQ3: begin
          t.sr  = close_fn(x, 6'd0, 2'd2);
          t.ret = is_d(c) ? RET_DONE : RET_REPLAY_3;
        end
        default: do_fail = 1'b1;
      endcase
    end
    if (do_fail) begin
      t.sr = fail_fn(x);
    end
    return t;
  endfunction

  // Resolves what is pending when the text ends.
  function automatic step_t finish_fn(step_t x);
    step_t o;
    o = x;
    if (!x.st.disc) begin
      unique case (x.st.esc)
        ESC_NONE: begin
          if (x.st.gpos != 2'd0) o = fail_fn(x);
        end
        ESC_P2_EQEQ:  o = pads_fn(x);
        ESC_P2_EQEQ3: o = fail_fn(pads_fn(x));
        ESC_P3_EQ:    o = close_fn(x, 6'd0, 2'd2);
        ESC_P3_EQ3:   o = fail_fn(close_fn(x, 6'd0, 2'd2));
        default:      o = fail_fn(x);
      endcase
    end
    return o;
  endfunction

  // Full work on one accepted character, replays and end of text included.
  function automatic step_t step_fn(dec_state_t s, logic [7:0] c, logic fin);
    step_t x;
    take_t t1;
    take_t t2;
    take_t t3;
    x.st = s;
    x.rs = '0;
    if (s.disc) begin
      if (fin) x.st = '0;
    end else begin
      t1 = take_fn(x, c);
      x  = t1.sr;
      if (t1.ret == RET_REPLAY_3) begin
        t2 = take_fn(x, CH_3);
        t3 = take_fn(t2.sr, c);
        x  = t3.sr;
      end else if (t1.ret == RET_REPLAY_C) begin
        t2 = take_fn(x, c);
        x  = t2.sr;
      end
      if (fin) begin
        x    = finish_fn(x);
        x.st = '0;
      end
    end
    return x;
  endfunction

endpackage

// ----- src/b64d_front.sv -----
// Front part: accepts characters, runs the decode state and builds result sets.
module b64d_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // text_char
  input  logic                in_tlast,   // text_end
  input  b64d_pkg::q_status_t q_stat,
  output logic                q_push,
  output b64d_pkg::entry_t    q_data
);

  b64d_pkg::dec_state_t st_r;
  b64d_pkg::dec_state_t st_nxt;
  b64d_pkg::step_t      step;
  logic                 accept;

  // Take a request whenever the queue has room for its results.
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Decode one character, with replays and end handling, in one pass.
  always_comb begin
    step   = b64d_pkg::step_fn(st_r, in_tdata, in_tlast);
    st_nxt = accept ? step.st : st_r;
  end

  // Requests that give no result leave nothing in the queue.
  assign q_push     = accept && (step.rs.cnt != 2'd0);
  assign q_data.rs  = step.rs;
  assign q_data.fin = in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ----- src/b64d_queue.sv -----
// Short queue of result sets between the front and back parts.
module b64d_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64d_pkg::entry_t    push_data,
  input  logic                pop,
  output b64d_pkg::entry_t    head,
  output b64d_pkg::q_status_t stat
);

  b64d_pkg::entry_t                  slot_r [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [b64d_pkg::QPTR_W-1:0]       wr_ptr_nxt;
  logic [b64d_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [b64d_pkg::QPTR_W-1:0]       rd_ptr_nxt;
  logic [b64d_pkg::QCNT_W-1:0]       cnt_r;
  logic [b64d_pkg::QCNT_W-1:0]       cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH));
  assign head       = slot_r[rd_ptr_r];

  // Pointers wrap on their own since the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/b64d_back.sv -----
// Back part: sends the results of each queued set one at a time.
module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  b64d_pkg::entry_t    head,
  input  b64d_pkg::q_status_t q_stat,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // data_byte
  output logic [1:0]          out_tuser,  // bad_input, run_last
  output logic                out_tlast   // text_done
);

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       bad_r;
  logic       bad_nxt;
  logic       run_last_r;
  logic       run_last_nxt;
  logic       done_r;
  logic       done_nxt;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       load;
  logic       last_of_set;

  // The output register takes a new result when empty or being taken.
  assign load        = !out_valid_r || out_tready;
  assign last_of_set = (idx_r == head.rs.cnt - 2'd1);
  assign q_pop       = load && !q_stat.empty && last_of_set;

  always_comb begin
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    bad_nxt       = bad_r;
    run_last_nxt  = run_last_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
      byte_nxt      = head.rs.data[idx_r];
      bad_nxt       = head.rs.bad[idx_r];
      run_last_nxt  = last_of_set;
      done_nxt      = head.rs.bad[idx_r] || (last_of_set && head.fin);
      if (!q_stat.empty) begin
        idx_nxt = last_of_set ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    bad_r      <= bad_nxt;
    run_last_r <= run_last_nxt;
    done_r     <= done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = {run_last_r, bad_r};
  assign out_tlast  = done_r;

endmodule

// ----- src/base64_decoder_qp_tolerant.sv -----
// A character's results pass through a queue slot and then the output register.
// Throughput: one character per cycle while the queue is not full; the output gives
// one result per cycle while out_tready is high, and a four-entry queue absorbs the
// difference. Reset (rst_n low, synchronous) clears the decode state, the queue and
// the output register at once; there is no clearing pass.
`include "base64_decoder_qp_tolerant_defines.svh"

module base64_decoder_qp_tolerant (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // text_char
  input  logic       in_tlast,   // text_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // data_byte
  output logic [1:0] out_tuser,  // bad_input, run_last
  output logic       out_tlast   // text_done
);

  b64d_pkg::q_status_t q_stat;
  b64d_pkg::entry_t    q_in;
  b64d_pkg::entry_t    q_head;
  logic                q_push;
  logic                q_pop;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // An error result always ends the text and the request's results.
  `B64D_ASSERT_IMPLY(a_bad_ends_text, out_tvalid && out_tuser[0], out_tlast && out_tuser[1])
  // The end of the text is always the last result of its request.
  `B64D_ASSERT_IMPLY(a_done_is_run_last, out_tvalid && out_tlast, out_tuser[1])
  // The queue never takes an entry when full.
  `B64D_ASSERT_IMPLY(a_push_room, q_push, !q_stat.full)
  // The queue never gives an entry when empty.
  `B64D_ASSERT_IMPLY(a_pop_data, q_pop, !q_stat.empty)
  // An empty queue with nothing pushed stays empty.
  `B64D_ASSERT_NEXT(a_empty_holds, q_stat.empty && !q_push, q_stat.empty)

endmodule

// ----- test/tb_base64_decoder_qp_tolerant.sv -----
// Self-checking testbench for the QP-tolerant base64 decoder: directed table, then random texts.
`timescale 1ns / 100ps

module tb_base64_decoder_qp_tolerant;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  // Block ports; the inputs are at known values from time zero.
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // text_char
  logic       in_tlast = 1'b0;    // text_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // data_byte
  logic [1:0] out_tuser;          // bad_input, run_last
  logic       out_tlast;          // text_done

  base64_decoder_qp_tolerant u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // One decoded byte or error, as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       done;
    logic       last;
  } decoded_t;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_ERROR
  } row_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    row_kind_t  kind;
  } dir_row_t;

  // Shapes of one random group of four sextets.
  typedef enum logic [2:0] {
    GRP_PLAIN,
    GRP_ESC_F,
    GRP_TWO_PADS,
    GRP_TWO_PADS_QP,
    GRP_ONE_PAD,
    GRP_ONE_PAD_QP
  } group_kind_t;

  // Ways a random text gets broken.
  typedef enum logic [1:0] {
    NOISE_BYTE,
    NOISE_CUT,
    NOISE_EQ
  } noise_t;

  localparam int RANDOM_ITEMS = 150;
  localparam int CALM_AFTER   = 120;

  // Decoded bytes still owed by the block, oldest first.
  decoded_t bytes_due[$];
  // Bytes produced by the character being predicted.
  decoded_t step_bytes[$];
  // Characters of the random text being sent.
  logic [7:0] text_buf[$];

  int  mismatches = 0;
  int  stall_left = 0;
  int  stall_pct = 0;
  logic calm = 1'b0;

  // Predictor state.
  logic [1:0]  dec_pos = 2'd0;
  logic [17:0] dec_sextets = 18'd0;
  logic [3:0]  dec_esc = b64d_pkg::ESC_NONE;
  logic        dec_halted = 1'b0;

  // Directed texts: plain quartet, high byte then discard, two pads, lone pad with replay
  // and incomplete end, broken escape, and a double pad followed by the one-pad escape.
  dir_row_t dir_rows [26] = '{
    '{"T", 1'b0, ROW_SILENT}, '{"W", 1'b0, ROW_SILENT}, '{"F", 1'b0, ROW_SILENT},
    '{"u", 1'b1, ROW_PREDICT},
    '{8'hFF, 1'b0, ROW_ERROR}, '{"A", 1'b0, ROW_SILENT}, '{"0", 1'b1, ROW_SILENT},
    '{"Q", 1'b0, ROW_SILENT}, '{"Q", 1'b0, ROW_SILENT}, '{"=", 1'b0, ROW_SILENT},
    '{"=", 1'b1, ROW_PREDICT},
    '{"Q", 1'b0, ROW_SILENT}, '{"U", 1'b0, ROW_SILENT}, '{"I", 1'b0, ROW_SILENT},
    '{"=", 1'b0, ROW_SILENT}, '{"Q", 1'b1, ROW_PREDICT},
    '{"=", 1'b0, ROW_SILENT}, '{"4", 1'b0, ROW_SILENT}, '{"x", 1'b1, ROW_ERROR},
    '{"A", 1'b0, ROW_SILENT}, '{"A", 1'b0, ROW_SILENT}, '{"=", 1'b0, ROW_SILENT},
    '{"=", 1'b0, ROW_SILENT}, '{"3", 1'b0, ROW_SILENT}, '{"d", 1'b0, ROW_ERROR},
    '{"=", 1'b1, ROW_SILENT}
  };

  // Prints one line per mismatch and counts them all.
  task automatic report_mismatch(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
    mismatches++;
  endtask

  // Sextet value of a character; bit 6 set when it is not in the alphabet.
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    if (c >= b64d_pkg::CH_UA && c <= b64d_pkg::CH_UZ) begin
      return {1'b0, 6'(c - b64d_pkg::CH_UA)};
    end
    if (c >= b64d_pkg::CH_LA && c <= b64d_pkg::CH_LZ) begin
      return {1'b0, 6'(c - b64d_pkg::CH_LA + 8'd26)};
    end
    if (c >= b64d_pkg::CH_0 && c <= b64d_pkg::CH_9) begin
      return {1'b0, 6'(c - b64d_pkg::CH_0 + 8'd52)};
    end
    if (c == b64d_pkg::CH_PLUS) return 7'd62;
    if (c == b64d_pkg::CH_DIV) return 7'd63;
    return 7'd64;
  endfunction

  function automatic logic is_letter_d(input logic [7:0] c);
    return (c == b64d_pkg::CH_UD) || (c == b64d_pkg::CH_LD);
  endfunction

  // Adds one byte to this character's results; a fourth one is dropped.
  task automatic add_byte(input logic [7:0] b, input logic bad);
    decoded_t r;
    if (step_bytes.size() < 3) begin
      r.data = b;
      r.bad  = bad;
      r.done = bad;
      r.last = 1'b0;
      step_bytes.push_back(r);
    end
  endtask

  task automatic clear_quartet();
    dec_pos     = 2'd0;
    dec_sextets = 18'd0;
    dec_esc     = b64d_pkg::ESC_NONE;
  endtask

  task automatic flag_error();
    add_byte(8'h00, 1'b1);
    clear_quartet();
    dec_halted = 1'b1;
  endtask

  task automatic append_sextet(input logic [5:0] v);
    dec_sextets = {dec_sextets[11:0], v};
  endtask

  // Turns the three stored sextets and s3 into nbytes bytes.
  task automatic close_quartet(input logic [5:0] s3, input int nbytes);
    logic [5:0] s0;
    logic [5:0] s1;
    logic [5:0] s2;
    s0 = dec_sextets[17:12];
    s1 = dec_sextets[11:6];
    s2 = dec_sextets[5:0];
    add_byte({s0, s1[5:4]}, 1'b0);
    if (nbytes > 1) add_byte({s1[3:0], s2[5:2]}, 1'b0);
    if (nbytes > 2) add_byte({s2[1:0], s3}, 1'b0);
    clear_quartet();
  endtask

  task automatic close_double_pad();
    append_sextet(6'd0);
    close_quartet(6'd0, 1);
  endtask

  // One pass of a character through the escape matcher; says what must be replayed.
  task automatic consume(input logic [7:0] c, output logic [1:0] replay);
    logic [6:0] sx;
    replay = b64d_pkg::RET_DONE;
    sx = sextet_value(c);
    if (!dec_halted) begin
      case (dec_esc)
        b64d_pkg::ESC_NONE: begin
          if (c == b64d_pkg::CH_EQ && dec_pos != 2'd1) begin
            dec_esc = (dec_pos == 2'd0) ? b64d_pkg::ESC_P0_EQ :
                      (dec_pos == 2'd2) ? b64d_pkg::ESC_P2_EQ : b64d_pkg::ESC_P3_EQ;
          end else if (sx[6]) begin
            flag_error();
          end else if (dec_pos == 2'd3) begin
            close_quartet(sx[5:0], 3);
          end else begin
            append_sextet(sx[5:0]);
            dec_pos = dec_pos + 2'd1;
          end
        end
        b64d_pkg::ESC_P0_EQ: begin
          if (c == b64d_pkg::CH_4) dec_esc = b64d_pkg::ESC_P0_EQ4;
          else flag_error();
        end
        b64d_pkg::ESC_P0_EQ4: begin
          if (c == b64d_pkg::CH_6) begin
            append_sextet(b64d_pkg::SX_F);
            dec_pos = 2'd1;
            dec_esc = b64d_pkg::ESC_NONE;
          end else begin
            flag_error();
          end
        end
        b64d_pkg::ESC_P2_EQ: begin
          if (c == b64d_pkg::CH_3) dec_esc = b64d_pkg::ESC_P2_EQ3;
          else if (c == b64d_pkg::CH_EQ) dec_esc = b64d_pkg::ESC_P2_EQEQ;
          else flag_error();
        end
        b64d_pkg::ESC_P2_EQ3: begin
          if (is_letter_d(c)) dec_esc = b64d_pkg::ESC_P2_EQ3D;
          else flag_error();
        end
        b64d_pkg::ESC_P2_EQ3D: begin
          if (c == b64d_pkg::CH_EQ) dec_esc = b64d_pkg::ESC_P2_EQ3DEQ;
          else flag_error();
        end
        b64d_pkg::ESC_P2_EQ3DEQ: begin
          if (c == b64d_pkg::CH_3) dec_esc = b64d_pkg::ESC_P2_EQ3DEQ3;
          else flag_error();
        end
        b64d_pkg::ESC_P2_EQ3DEQ3: begin
          if (is_letter_d(c)) close_double_pad();
          else flag_error();
        end
        b64d_pkg::ESC_P2_EQEQ: begin
          if (c == b64d_pkg::CH_3) begin
            dec_esc = b64d_pkg::ESC_P2_EQEQ3;
          end else begin
            close_double_pad();
            replay = b64d_pkg::RET_REPLAY_C;
          end
        end
        b64d_pkg::ESC_P2_EQEQ3: begin
          // A "d" here would complete a one-pad escape, which fits nowhere.
          if (is_letter_d(c)) begin
            flag_error();
          end else begin
            close_double_pad();
            replay = b64d_pkg::RET_REPLAY_3;
          end
        end
        b64d_pkg::ESC_P3_EQ: begin
          if (c == b64d_pkg::CH_3) begin
            dec_esc = b64d_pkg::ESC_P3_EQ3;
          end else begin
            close_quartet(6'd0, 2);
            replay = b64d_pkg::RET_REPLAY_C;
          end
        end
        b64d_pkg::ESC_P3_EQ3: begin
          close_quartet(6'd0, 2);
          replay = is_letter_d(c) ? b64d_pkg::RET_DONE : b64d_pkg::RET_REPLAY_3;
        end
        default: flag_error();
      endcase
    end
  endtask

  // Settles whatever is pending when the text ends.
  task automatic wrap_up();
    if (!dec_halted) begin
      case (dec_esc)
        b64d_pkg::ESC_NONE: begin
          if (dec_pos != 2'd0) flag_error();
        end
        b64d_pkg::ESC_P2_EQEQ: close_double_pad();
        b64d_pkg::ESC_P2_EQEQ3: begin
          close_double_pad();
          flag_error();
        end
        b64d_pkg::ESC_P3_EQ: close_quartet(6'd0, 2);
        b64d_pkg::ESC_P3_EQ3: begin
          close_quartet(6'd0, 2);
          flag_error();
        end
        default: flag_error();
      endcase
    end
  endtask

  // Sets the given flags on the newest result of this character.
  task automatic mark_tail(input logic set_done);
    decoded_t r;
    if (step_bytes.size() != 0) begin
      r = step_bytes.pop_back();
      r.last = 1'b1;
      if (set_done) r.done = 1'b1;
      step_bytes.push_back(r);
    end
  endtask

  // Works out the results of one accepted character into step_bytes.
  task automatic predict_char(input logic [7:0] c, input logic fin);
    logic [1:0] replay;
    logic [1:0] ignored;
    step_bytes.delete();
    if (dec_halted) begin
      if (fin) begin
        clear_quartet();
        dec_halted = 1'b0;
      end
    end else begin
      consume(c, replay);
      if (replay == b64d_pkg::RET_REPLAY_3) begin
        consume(b64d_pkg::CH_3, ignored);
        consume(c, ignored);
      end else if (replay == b64d_pkg::RET_REPLAY_C) begin
        consume(c, ignored);
      end
      if (fin) begin
        wrap_up();
        mark_tail(1'b1);
        clear_quartet();
        dec_halted = 1'b0;
      end
      mark_tail(1'b0);
    end
  endtask

  // Holds one request on the input until the block takes it.
  task automatic send_char(input logic [7:0] c, input logic fin, input int gap_pct);
    int gap;
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [7:0] char_of_sextet(input logic [5:0] v);
    if (v < 6'd26) return b64d_pkg::CH_UA + 8'(v);
    if (v < 6'd52) return b64d_pkg::CH_LA + 8'(v - 6'd26);
    if (v < 6'd62) return b64d_pkg::CH_0 + 8'(v - 6'd52);
    if (v == 6'd62) return b64d_pkg::CH_PLUS;
    return b64d_pkg::CH_DIV;
  endfunction

  // Alphabet character, leaning toward the ones the escapes look at.
  function automatic logic [7:0] content_char();
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 4))
        0: return b64d_pkg::CH_3;
        1: return b64d_pkg::CH_LD;
        2: return b64d_pkg::CH_UD;
        3: return b64d_pkg::CH_4;
        default: return b64d_pkg::CH_6;
      endcase
    end
    return char_of_sextet(6'($urandom_range(0, 63)));
  endfunction

  function automatic logic [7:0] any_case_d();
    return $urandom_range(0, 1) ? b64d_pkg::CH_LD : b64d_pkg::CH_UD;
  endfunction

  // Builds a random text of well-formed groups, now and then broken.
  task automatic build_text();
    int groups;
    int pos;
    group_kind_t kind;
    noise_t noise;
    text_buf.delete();
    groups = $urandom_range(1, 3);
    for (int g = 0; g < groups; g++) begin
      kind = group_kind_t'($urandom_range(0, 5));
      case (kind)
        GRP_PLAIN: repeat (4) text_buf.push_back(content_char());
        GRP_ESC_F: begin
          text_buf.push_back(b64d_pkg::CH_EQ);
          text_buf.push_back(b64d_pkg::CH_4);
          text_buf.push_back(b64d_pkg::CH_6);
          repeat (3) text_buf.push_back(content_char());
        end
        GRP_TWO_PADS: begin
          repeat (2) text_buf.push_back(content_char());
          text_buf.push_back(b64d_pkg::CH_EQ);
          text_buf.push_back(b64d_pkg::CH_EQ);
        end
        GRP_TWO_PADS_QP: begin
          repeat (2) text_buf.push_back(content_char());
          repeat (2) begin
            text_buf.push_back(b64d_pkg::CH_EQ);
            text_buf.push_back(b64d_pkg::CH_3);
            text_buf.push_back(any_case_d());
          end
        end
        GRP_ONE_PAD: begin
          repeat (3) text_buf.push_back(content_char());
          text_buf.push_back(b64d_pkg::CH_EQ);
        end
        default: begin
          repeat (3) text_buf.push_back(content_char());
          text_buf.push_back(b64d_pkg::CH_EQ);
          text_buf.push_back(b64d_pkg::CH_3);
          text_buf.push_back(any_case_d());
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      noise = noise_t'($urandom_range(0, 2));
      pos = $urandom_range(0, text_buf.size() - 1);
      case (noise)
        NOISE_BYTE: text_buf[pos] = 8'($urandom_range(0, 255));
        NOISE_CUT: begin
          repeat ($urandom_range(1, 3)) begin
            if (text_buf.size() > 1) void'(text_buf.pop_back());
          end
        end
        default: text_buf.insert(pos, b64d_pkg::CH_EQ);
      endcase
    end
  endtask

  // Random stalls on the result side.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
      stall_left <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compares each accepted result with the oldest outstanding one.
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (bytes_due.size() == 0) begin
        report_mismatch("unexpected result, data", 0, out_tdata);
      end else begin
        want = bytes_due.pop_front();
        if (out_tdata !== want.data) report_mismatch("data_byte", want.data, out_tdata);
        if (out_tuser[0] !== want.bad) report_mismatch("bad_input", want.bad, out_tuser[0]);
        if (out_tlast !== want.done) report_mismatch("text_done", want.done, out_tlast);
        if (out_tuser[1] !== want.last) report_mismatch("run_last", want.last, out_tuser[1]);
      end
    end
  end

  // Reset, directed table, random texts, then drain and verdict.
  initial begin : stimulus
    decoded_t err_res;
    int sent;
    int gap_pct;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    err_res.data = 8'h00;
    err_res.bad  = 1'b1;
    err_res.done = 1'b1;
    err_res.last = 1'b1;

    stall_pct = 20;
    foreach (dir_rows[i]) begin
      send_char(dir_rows[i].ch, dir_rows[i].fin, 25);
      predict_char(dir_rows[i].ch, dir_rows[i].fin);
      case (dir_rows[i].kind)
        ROW_ERROR: bytes_due.push_back(err_res);
        ROW_SILENT: ;
        default: foreach (step_bytes[k]) bytes_due.push_back(step_bytes[k]);
      endcase
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      build_text();
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 12;
        default: stall_pct = 30;
      endcase
      foreach (text_buf[i]) begin
        if (sent >= CALM_AFTER) calm = 1'b1;
        send_char(text_buf[i], i == text_buf.size() - 1, gap_pct);
        predict_char(text_buf[i], i == text_buf.size() - 1);
        foreach (step_bytes[k]) bytes_due.push_back(step_bytes[k]);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (bytes_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog that ends a run which hangs.
  initial begin
    #500000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64_decoder_qp_tolerant.sv
test/tb_base64_decoder_qp_tolerant.sv
